>>> rtl/core/three_tap_audio_echo_macros.svh
// ----------------------------------------------------------------------------
// three_tap_audio_echo assertion macros
// shared concurrent assertion forms for the echo core
// ----------------------------------------------------------------------------
`ifndef THREE_TAP_AUDIO_ECHO_MACROS_SVH
`define THREE_TAP_AUDIO_ECHO_MACROS_SVH

// consequent checked in the same cycle
`define TAE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("three_tap_audio_echo: assertion failed");

// consequent checked in the following cycle
`define TAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("three_tap_audio_echo: assertion failed");

`endif

>>> rtl/core/tae_pkg.sv
// ----------------------------------------------------------------------------
// tae_pkg
// types and constants shared by the three tap audio echo core
// ----------------------------------------------------------------------------
package tae_pkg;

    localparam int SAMPLE_W = 8;
    localparam int DELAY_W  = 16;
    localparam int GAIN_W   = 8;
    localparam int RECIP_W  = 16;
    localparam int INDEX_W  = 3;
    localparam int DATA_W   = 16;

    // centered sample, gain product, accumulator and normalized product
    localparam int TAP_W  = SAMPLE_W + 1;
    localparam int PROD_W = 2 * TAP_W;
    localparam int ACC_W  = 20;
    localparam int P_W    = ACC_W + RECIP_W + 1;
    localparam int SUM_W  = P_W + 1;
    localparam int FRAC_W = 24;

    localparam logic [SAMPLE_W-1:0] OFFSET = 8'd128;
    localparam logic [SUM_W-1:0] ROUND_BIAS =
        (SUM_W'(128) << FRAC_W) + (SUM_W'(1) << (FRAC_W - 1));

    typedef logic [INDEX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_DELAY_ONE   = 3'd0;
    localparam cfg_idx_t REG_DELAY_TWO   = 3'd1;
    localparam cfg_idx_t REG_DELAY_THREE = 3'd2;
    localparam cfg_idx_t REG_GAIN_ONE    = 3'd3;
    localparam cfg_idx_t REG_GAIN_TWO    = 3'd4;
    localparam cfg_idx_t REG_GAIN_THREE  = 3'd5;
    localparam cfg_idx_t REG_NORM_RECIP  = 3'd6;

    localparam logic [DELAY_W-1:0] RST_DELAY_ONE   = 16'd14666;
    localparam logic [DELAY_W-1:0] RST_DELAY_TWO   = 16'd22000;
    localparam logic [DELAY_W-1:0] RST_DELAY_THREE = 16'd44000;
    localparam logic [GAIN_W-1:0]  RST_GAIN_ONE    = 8'd128;
    localparam logic [GAIN_W-1:0]  RST_GAIN_TWO    = 8'd102;
    localparam logic [GAIN_W-1:0]  RST_GAIN_THREE  = 8'd77;
    localparam logic [RECIP_W-1:0] RST_NORM_RECIP  = 16'd29800;

    typedef logic [1:0] tap_sel_t;

    localparam tap_sel_t TAP_ONE   = 2'd0;
    localparam tap_sel_t TAP_TWO   = 2'd1;
    localparam tap_sel_t TAP_THREE = 2'd2;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_one;
        logic [DELAY_W-1:0] delay_two;
        logic [DELAY_W-1:0] delay_three;
        logic [GAIN_W-1:0]  gain_one;
        logic [GAIN_W-1:0]  gain_two;
        logic [GAIN_W-1:0]  gain_three;
        logic [RECIP_W-1:0] norm_recip;
    } cfg_t;

    typedef struct packed {
        logic     load;
        tap_sel_t rd_sel;
        tap_sel_t acc_sel;
        logic     acc_init;
        logic     acc_en;
        logic     wr_en;
        logic     mul_en;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

>>> rtl/core/tae_ifs.sv
// ----------------------------------------------------------------------------
// tae interfaces
// valid/ready channels for samples, echoed samples and register writes
// ----------------------------------------------------------------------------
interface tae_sample_if;
    logic                          valid;
    logic                          ready;
    logic [tae_pkg::SAMPLE_W-1:0] sample_in;
    logic                          restart;

    modport source (output valid, output sample_in, output restart, input ready);
    modport sink (input valid, input sample_in, input restart, output ready);
endinterface

interface tae_echo_if;
    logic                          valid;
    logic                          ready;
    logic [tae_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

interface tae_cfg_if;
    logic                        valid;
    logic                        ready;
    tae_pkg::cfg_idx_t           index;
    logic [tae_pkg::DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/core/tae_cfg.sv
// ----------------------------------------------------------------------------
// tae_cfg
// register file for tap delays, tap gains and the normalizing reciprocal
// ----------------------------------------------------------------------------
module tae_cfg (
    input  logic          clk,
    input  logic          rst_n,
    tae_cfg_if.sink       cfg,
    output tae_pkg::cfg_t regs
);

    tae_pkg::cfg_t regs_reg;
    tae_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                tae_pkg::REG_DELAY_ONE:   regs_next.delay_one   = cfg.wdata;
                tae_pkg::REG_DELAY_TWO:   regs_next.delay_two   = cfg.wdata;
                tae_pkg::REG_DELAY_THREE: regs_next.delay_three = cfg.wdata;
                tae_pkg::REG_GAIN_ONE:    regs_next.gain_one    = cfg.wdata[tae_pkg::GAIN_W-1:0];
                tae_pkg::REG_GAIN_TWO:    regs_next.gain_two    = cfg.wdata[tae_pkg::GAIN_W-1:0];
                tae_pkg::REG_GAIN_THREE:  regs_next.gain_three  = cfg.wdata[tae_pkg::GAIN_W-1:0];
                tae_pkg::REG_NORM_RECIP:  regs_next.norm_recip  = cfg.wdata;
                default:                  regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.delay_one   <= tae_pkg::RST_DELAY_ONE;
            regs_reg.delay_two   <= tae_pkg::RST_DELAY_TWO;
            regs_reg.delay_three <= tae_pkg::RST_DELAY_THREE;
            regs_reg.gain_one    <= tae_pkg::RST_GAIN_ONE;
            regs_reg.gain_two    <= tae_pkg::RST_GAIN_TWO;
            regs_reg.gain_three  <= tae_pkg::RST_GAIN_THREE;
            regs_reg.norm_recip  <= tae_pkg::RST_NORM_RECIP;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

>>> rtl/core/tae_ctrl.sv
// ----------------------------------------------------------------------------
// tae_ctrl
// sequencer for tap reads, ring write, normalize and output load
// ----------------------------------------------------------------------------
`include "three_tap_audio_echo_macros.svh"

module tae_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tae_pkg::sts_t sts,
    output tae_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_READ_TWO   = 3'd1;
    localparam logic [2:0] S_READ_THREE = 3'd2;
    localparam logic [2:0] S_WRITE      = 3'd3;
    localparam logic [2:0] S_MUL        = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       res_pending_reg;
    logic       res_pending_next;

    always_comb
    begin
        state_next       = state_reg;
        res_pending_next = res_pending_reg;
        in_ready         = 1'b0;
        cmd              = '0;
        cmd.rd_sel       = tae_pkg::TAP_ONE;
        cmd.acc_sel      = tae_pkg::TAP_ONE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.out_load = res_pending_reg && sts.out_free;
                in_ready     = !res_pending_reg || sts.out_free;
                if (cmd.out_load)
                begin
                    res_pending_next = 1'b0;
                end
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ_TWO;
                end
            end
            S_READ_TWO:
            begin
                cmd.rd_sel   = tae_pkg::TAP_TWO;
                cmd.acc_sel  = tae_pkg::TAP_ONE;
                cmd.acc_init = 1'b1;
                cmd.acc_en   = 1'b1;
                state_next   = S_READ_THREE;
            end
            S_READ_THREE:
            begin
                cmd.rd_sel  = tae_pkg::TAP_THREE;
                cmd.acc_sel = tae_pkg::TAP_TWO;
                cmd.acc_en  = 1'b1;
                state_next  = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.acc_sel = tae_pkg::TAP_THREE;
                cmd.acc_en  = 1'b1;
                cmd.wr_en   = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en       = 1'b1;
                res_pending_next = 1'b1;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            res_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            res_pending_reg <= res_pending_next;
        end
    end

    `TAE_ASSERT_NEXT(a_transfer_starts_reads, clk, rst_n, in_valid && in_ready, state_reg == S_READ_TWO)
    `TAE_ASSERT_NEXT(a_mul_leaves_result, clk, rst_n, state_reg == S_MUL, res_pending_reg)
    `TAE_ASSERT_SAME(a_write_after_reads, clk, rst_n, state_reg == S_WRITE, $past(state_reg) == S_READ_THREE)
    `TAE_ASSERT_NEXT(a_stalled_result_held, clk, rst_n, state_reg == S_IDLE && res_pending_reg && !sts.out_free, res_pending_reg && state_reg == S_IDLE)

endmodule

>>> rtl/core/tae_dp.sv
// ----------------------------------------------------------------------------
// tae_dp
// history ring, tap accumulate, normalize multiply and output register
// ----------------------------------------------------------------------------
module tae_dp #(
    parameter int HISTORY_DEPTH = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tae_pkg::cmd_t                 cmd,
    output tae_pkg::sts_t                 sts,
    input  tae_pkg::cfg_t                 regs,
    input  logic [tae_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                          restart,
    output logic [tae_pkg::SAMPLE_W-1:0] sample_out,
    output logic                          out_valid,
    input  logic                          out_ready
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = ((AW > tae_pkg::DELAY_W) ? AW : tae_pkg::DELAY_W) + 2;
    localparam logic [AW-1:0] WP_LAST  = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(HISTORY_DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(HISTORY_DEPTH);

    logic [tae_pkg::SAMPLE_W-1:0] ring_mem [HISTORY_DEPTH];

    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] cnt_eff;

    logic [tae_pkg::SAMPLE_W-1:0] raw_reg;
    logic [tae_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [2:0]                    tap_valid_reg;
    logic [2:0]                    tap_zero_reg;

    logic signed [tae_pkg::ACC_W-1:0] acc_reg;
    logic signed [tae_pkg::ACC_W-1:0] acc_next;
    logic signed [tae_pkg::P_W-1:0]   p_reg;
    logic signed [tae_pkg::P_W-1:0]   p_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [tae_pkg::SAMPLE_W-1:0] sample_out_reg;
    logic [tae_pkg::SAMPLE_W-1:0] sample_out_next;

    logic [tae_pkg::DELAY_W-1:0] rd_delay;
    logic [SW-1:0]               wp_ext;
    logic [SW-1:0]               d_ext;
    logic [SW-1:0]               diff;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               mem_addr;

    logic signed [tae_pkg::TAP_W-1:0]  x_val;
    logic signed [tae_pkg::TAP_W-1:0]  ring_val;
    logic signed [tae_pkg::TAP_W-1:0]  tap_val;
    logic signed [tae_pkg::TAP_W-1:0]  gain_s;
    logic [tae_pkg::GAIN_W-1:0]        gain_sel;
    logic                              sel_valid;
    logic                              sel_zero;
    logic signed [tae_pkg::PROD_W-1:0] prod;
    logic signed [tae_pkg::ACC_W-1:0]  prod_ext;
    logic signed [tae_pkg::ACC_W-1:0]  x_base;
    logic [tae_pkg::SUM_W-1:0]         round_sum;

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign sample_out   = sample_out_reg;

    // ring address of the selected tap
    always_comb
    begin
        case (cmd.rd_sel)
            tae_pkg::TAP_ONE:   rd_delay = regs.delay_one;
            tae_pkg::TAP_TWO:   rd_delay = regs.delay_two;
            tae_pkg::TAP_THREE: rd_delay = regs.delay_three;
            default:            rd_delay = regs.delay_one;
        endcase
        wp_ext = SW'(wp_reg);
        d_ext  = SW'(rd_delay);
        if (wp_ext >= d_ext)
        begin
            diff = wp_ext - d_ext;
        end
        else
        begin
            diff = wp_ext + DEPTH_S - d_ext;
        end
        rd_addr = diff[AW-1:0];
    end

    assign mem_addr = cmd.wr_en ? wp_reg : rd_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            ring_mem[mem_addr] <= raw_reg;
        end
        else
        begin
            rd_data_reg <= ring_mem[mem_addr];
        end
    end

    // tap value and gain for the data arriving from the ring
    always_comb
    begin
        case (cmd.acc_sel)
            tae_pkg::TAP_ONE:
            begin
                gain_sel  = regs.gain_one;
                sel_valid = tap_valid_reg[0];
                sel_zero  = tap_zero_reg[0];
            end
            tae_pkg::TAP_TWO:
            begin
                gain_sel  = regs.gain_two;
                sel_valid = tap_valid_reg[1];
                sel_zero  = tap_zero_reg[1];
            end
            tae_pkg::TAP_THREE:
            begin
                gain_sel  = regs.gain_three;
                sel_valid = tap_valid_reg[2];
                sel_zero  = tap_zero_reg[2];
            end
            default:
            begin
                gain_sel  = '0;
                sel_valid = 1'b0;
                sel_zero  = 1'b0;
            end
        endcase
        x_val    = $signed({1'b0, raw_reg}) - $signed({1'b0, tae_pkg::OFFSET});
        ring_val = $signed({1'b0, rd_data_reg}) - $signed({1'b0, tae_pkg::OFFSET});
        if (sel_zero)
        begin
            tap_val = x_val;
        end
        else if (sel_valid)
        begin
            tap_val = ring_val;
        end
        else
        begin
            tap_val = '0;
        end
        gain_s   = $signed({1'b0, gain_sel});
        prod     = gain_s * tap_val;
        prod_ext = {{(tae_pkg::ACC_W - tae_pkg::PROD_W){prod[tae_pkg::PROD_W-1]}}, prod};
        x_base   = {{(tae_pkg::ACC_W - tae_pkg::TAP_W - 8){x_val[tae_pkg::TAP_W-1]}},
                    x_val, 8'd0};
        acc_next = cmd.acc_init ? (x_base + prod_ext) : (acc_reg + prod_ext);
    end

    assign p_next = acc_reg * $signed({1'b0, regs.norm_recip});

    // round half up, re-offset and saturate
    always_comb
    begin
        round_sum = {p_reg[tae_pkg::P_W-1], p_reg} + tae_pkg::ROUND_BIAS;
        if (round_sum[tae_pkg::SUM_W-1])
        begin
            sample_out_next = '0;
        end
        else if (|round_sum[tae_pkg::SUM_W-2:tae_pkg::FRAC_W+tae_pkg::SAMPLE_W])
        begin
            sample_out_next = '1;
        end
        else
        begin
            sample_out_next =
                round_sum[tae_pkg::FRAC_W+tae_pkg::SAMPLE_W-1:tae_pkg::FRAC_W];
        end
    end

    assign cnt_eff = restart ? '0 : cnt_reg;

    always_comb
    begin
        wp_next  = wp_reg;
        cnt_next = cnt_reg;
        if (cmd.load && restart)
        begin
            wp_next  = '0;
            cnt_next = '0;
        end
        else if (cmd.wr_en)
        begin
            wp_next  = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
            cnt_next = (cnt_reg == CNT_FULL) ? cnt_reg : cnt_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg          <= sample_in;
            tap_zero_reg[0]  <= regs.delay_one == '0;
            tap_zero_reg[1]  <= regs.delay_two == '0;
            tap_zero_reg[2]  <= regs.delay_three == '0;
            tap_valid_reg[0] <= SW'(cnt_eff) >= SW'(regs.delay_one);
            tap_valid_reg[1] <= SW'(cnt_eff) >= SW'(regs.delay_two);
            tap_valid_reg[2] <= SW'(cnt_eff) >= SW'(regs.delay_three);
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.mul_en)
        begin
            p_reg <= p_next;
        end
        if (cmd.out_load)
        begin
            sample_out_reg <= sample_out_next;
        end
    end

endmodule

>>> rtl/core/three_tap_audio_echo.sv
// ----------------------------------------------------------------------------
// three_tap_audio_echo
// feedforward echo with three delayed, weighted taps on 8-bit audio
// ----------------------------------------------------------------------------
// sample_ch carries one unsigned sample (128 is silence) and a restart flag
// that clears history before that sample; echo_ch returns one echoed sample
// per input, in order; cfg writes tap delays, tap gains and the normalizing
// reciprocal by register index; cfg is to be written only while the core is
// idle, which the user must keep to: the core itself does not enforce it.
// for each sample the single-port history ring serves three tap reads and
// one write on consecutive cycles, then the normalizing multiply follows,
// and the next sample is taken only after the core returns to idle.
// a finished result sits in the output register, so the next sample is
// taken while echo_ch stalls; a second result waits until the first one
// leaves, and sample_ch holds ready low meanwhile.
// reset sets the registers to their defaults, empties the history and clears
// the output; ring contents need no clearing since only written entries are
// ever read
// ----------------------------------------------------------------------------
module three_tap_audio_echo #(
    parameter int HISTORY_DEPTH = 65536
) (
    input  logic         clk,
    input  logic         rst_n,
    tae_sample_if.sink   sample_ch,
    tae_echo_if.source   echo_ch,
    tae_cfg_if.sink      cfg
);

    tae_pkg::cfg_t regs;
    tae_pkg::cmd_t cmd;
    tae_pkg::sts_t sts;

    tae_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    tae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_ch.valid),
        .in_ready (sample_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tae_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .regs       (regs),
        .sample_in  (sample_ch.sample_in),
        .restart    (sample_ch.restart),
        .sample_out (echo_ch.sample_out),
        .out_valid  (echo_ch.valid),
        .out_ready  (echo_ch.ready)
    );

endmodule
